FILE: rtl/sqrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad rotate/scale package
// Shared types, register codes and widths for the sprite quad generator.
// ----------------------------------------------------------------------------
package sqrs_pkg;

  localparam int unsigned COORD_FRAC_BITS_DEF = 4;
  localparam int unsigned TRIG_FRAC_BITS_DEF  = 16;

  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned SCALE_FRAC = 12;
  localparam int unsigned OFF_W      = 14;  // corner offset from the pivot, texels
  localparam int unsigned OX_W       = 30;  // offset times scale
  localparam int unsigned BS_W       = 13;  // position plus pivot
  localparam int unsigned N_W        = 13;  // clip edge
  localparam int unsigned DIV_W      = 14;  // twice the texture size
  localparam int unsigned TEX_Q_W    = 16;
  localparam int unsigned VERT_W     = 20;

  localparam logic [12:0] TEX_SIZE_RST = 13'd256;

  typedef enum logic [2:0] {
    REG_PIVOT_X    = 3'd0,
    REG_PIVOT_Y    = 3'd1,
    REG_ROT_ANGLE  = 3'd2,
    REG_TEX_WIDTH  = 3'd3,
    REG_TEX_HEIGHT = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    TRIG_IDLE,
    TRIG_TH,
    TRIG_SQ,
    TRIG_MUL,
    TRIG_DIV,
    TRIG_SIN,
    TRIG_FIN
  } trig_state_e;

  typedef struct packed {
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [11:0]        clip_x;
    logic [11:0]        clip_y;
    logic [11:0]        clip_w;
    logic [11:0]        clip_h;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic [31:0]        color;
  } sprite_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [19:0] vert_x;
    logic signed [19:0] vert_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vert_color;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } trig_req_t;

endpackage

FILE: rtl/sqrs_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad stream interface
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface sqrs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sprite_quad_rotate_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad rotate/scale
// Turns one sprite draw request into four rotated, scaled corner vertices.
// ----------------------------------------------------------------------------
// Flow: a request passes the entry stage, the texture division stages and
// the corner stages; the last division stage holds each sprite until its
// four corners have gone on, one at a time, to the single vertex output port.
// A write to the rotation angle starts the sine/cosine sequence; sprite
// requests are held off until it finishes.
// Reset: pivot 0, angle 0, texture 256 x 256, all pipeline stages empty.
module sprite_quad_rotate_scale #(
  parameter int unsigned COORD_FRAC_BITS = sqrs_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS  = sqrs_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sqrs_stream_if.sink                  sprite_i,
  sqrs_stream_if.source                vert_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sqrs_pkg::PADDR_W-1:0] paddr,
  input  logic [sqrs_pkg::PDATA_W-1:0] pwdata,
  output logic [sqrs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import sqrs_pkg::*;

  localparam int unsigned TW    = TRIG_FRAC_BITS + 2;
  localparam int unsigned FR    = SCALE_FRAC + TRIG_FRAC_BITS;
  localparam int unsigned RS    = FR - COORD_FRAC_BITS;
  localparam int unsigned P_W   = OX_W + TW;
  localparam int unsigned SUM_W = P_W + 2;
  localparam longint BIAS_L = (longint'(1) << (RS - 1)) - (longint'(1) << (FR - 1));
  localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(BIAS_L);
  localparam logic signed [SUM_W-1:0] VMAX = SUM_W'(524287);
  localparam logic signed [SUM_W-1:0] VMIN = -SUM_W'(524288);

  typedef struct packed {
    logic signed [OFF_W-1:0] offx0;
    logic signed [OFF_W-1:0] offx1;
    logic signed [OFF_W-1:0] offy0;
    logic signed [OFF_W-1:0] offy1;
    logic signed [SUM_W-1:0] basex;
    logic signed [SUM_W-1:0] basey;
    logic [15:0]             sx;
    logic [15:0]             sy;
    logic [31:0]             color;
    logic [3:0][N_W-1:0]     num;
    logic [3:0][DIV_W-1:0]   rem;
    logic [3:0][TEX_Q_W-1:0] quo;
    logic [3:0]              sat;
    logic [DIV_W-1:0]        du;
    logic [DIV_W-1:0]        dv;
  } spr_t;

  typedef struct packed {
    logic [1:0]              k;
    logic signed [OX_W-1:0]  ox;
    logic signed [OX_W-1:0]  oy;
    logic signed [SUM_W-1:0] basex;
    logic signed [SUM_W-1:0] basey;
    logic [15:0]             u;
    logic [15:0]             v;
    logic [31:0]             color;
  } c1_t;

  typedef struct packed {
    logic [1:0]              k;
    logic signed [P_W-1:0]   pxc;
    logic signed [P_W-1:0]   pys;
    logic signed [P_W-1:0]   pxs;
    logic signed [P_W-1:0]   pyc;
    logic signed [SUM_W-1:0] basex;
    logic signed [SUM_W-1:0] basey;
    logic [15:0]             u;
    logic [15:0]             v;
    logic [31:0]             color;
  } c2_t;

  typedef struct packed {
    logic [1:0]              k;
    logic signed [SUM_W-1:0] rx;
    logic signed [SUM_W-1:0] ry;
    logic [15:0]             u;
    logic [15:0]             v;
    logic [31:0]             color;
  } c3_t;

  // Configuration registers
  logic signed [11:0] pivot_x_q, pivot_y_q;
  logic [15:0]        angle_q;
  logic [12:0]        tex_w_q, tex_h_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;
  trig_req_t          trig_req;
  logic signed [TW-1:0] sine, cosine;
  logic               trig_busy;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q <= '0;
      pivot_y_q <= '0;
      angle_q   <= '0;
      tex_w_q   <= TEX_SIZE_RST;
      tex_h_q   <= TEX_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PIVOT_X:    pivot_x_q <= pwdata[11:0];
        REG_PIVOT_Y:    pivot_y_q <= pwdata[11:0];
        REG_ROT_ANGLE:  angle_q   <= pwdata[15:0];
        REG_TEX_WIDTH:  tex_w_q   <= pwdata[12:0];
        REG_TEX_HEIGHT: tex_h_q   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PIVOT_X:    prdata = PDATA_W'(pivot_x_q);
      REG_PIVOT_Y:    prdata = PDATA_W'(pivot_y_q);
      REG_ROT_ANGLE:  prdata = PDATA_W'(angle_q);
      REG_TEX_WIDTH:  prdata = PDATA_W'(tex_w_q);
      REG_TEX_HEIGHT: prdata = PDATA_W'(tex_h_q);
      default:        prdata = '0;
    endcase
  end

  assign trig_req.start = cfg_wr && (cfg_idx == REG_ROT_ANGLE);
  assign trig_req.angle = pwdata[15:0];

  sqrs_trig #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (trig_req),
    .sine_o   (sine),
    .cosine_o (cosine),
    .busy_o   (trig_busy)
  );

  // Sprite pipeline: entry stage, then four stages of texture division
  spr_t       sp_q [5];
  spr_t       sp_nxt [4];
  spr_t       sp_in;
  logic [4:0] sv_q;
  logic [4:0] s_rdy;
  logic [1:0] cnt_q;
  logic       emit;
  logic [3:0] c_rdy;
  logic [3:0] cv_q;

  always_comb begin
    sprite_t                in;
    logic signed [BS_W-1:0] bsx, bsy;
    logic [12:0]            tw, th;
    in  = sprite_i.data;
    tw  = (tex_w_q == '0) ? 13'd1 : tex_w_q;
    th  = (tex_h_q == '0) ? 13'd1 : tex_h_q;
    bsx = BS_W'(in.pos_x) + BS_W'(pivot_x_q);
    bsy = BS_W'(in.pos_y) + BS_W'(pivot_y_q);
    sp_in        = '0;
    sp_in.offx0  = -OFF_W'(pivot_x_q);
    sp_in.offx1  = $signed(OFF_W'(in.clip_w)) - OFF_W'(pivot_x_q);
    sp_in.offy0  = -OFF_W'(pivot_y_q);
    sp_in.offy1  = $signed(OFF_W'(in.clip_h)) - OFF_W'(pivot_y_q);
    sp_in.basex  = (SUM_W'(bsx) <<< FR) + RND_BIAS;
    sp_in.basey  = (SUM_W'(bsy) <<< FR) + RND_BIAS;
    sp_in.sx     = in.scale_x;
    sp_in.sy     = in.scale_y;
    sp_in.color  = in.color;
    sp_in.num[0] = N_W'(in.clip_x);
    sp_in.num[1] = N_W'(in.clip_x) + N_W'(in.clip_w);
    sp_in.num[2] = N_W'(in.clip_y);
    sp_in.num[3] = N_W'(in.clip_y) + N_W'(in.clip_h);
    sp_in.du     = {tw, 1'b0};
    sp_in.dv     = {th, 1'b0};
  end

  // u = ((n << 16) + d) / 2d. The quotient saturates exactly when n >= 2d,
  // otherwise n is the first remainder and the bits of d are brought down.
  always_comb begin
    logic [DIV_W-1:0] dd;
    logic [15:0]      dlo;
    logic [DIV_W-1:0] r;
    logic [DIV_W:0]   t;
    for (int j = 0; j < 4; j++) begin
      sp_nxt[j] = sp_q[j];
      for (int l = 0; l < 4; l++) begin
        dd  = (l < 2) ? sp_q[j].du : sp_q[j].dv;
        dlo = 16'(dd[DIV_W-1:1]);
        r   = sp_q[j].rem[l];
        if (j == 0) begin
          sp_nxt[j].sat[l] = DIV_W'(sp_q[j].num[l]) >= dd;
          r = DIV_W'(sp_q[j].num[l]);
        end
        for (int i = 0; i < 4; i++) begin
          t = {r, dlo[15 - 4*j - i]};
          if (t >= {1'b0, dd}) begin
            r = DIV_W'(t - {1'b0, dd});
            sp_nxt[j].quo[l][15 - 4*j - i] = 1'b1;
          end else begin
            r = t[DIV_W-1:0];
            sp_nxt[j].quo[l][15 - 4*j - i] = 1'b0;
          end
        end
        sp_nxt[j].rem[l] = r;
      end
    end
  end

  assign emit     = sv_q[4] && c_rdy[0];
  assign s_rdy[4] = !sv_q[4] || (emit && (cnt_q == 2'd3));
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s_rdy[i] = !sv_q[i] || s_rdy[i+1];
    end
  end
  assign sprite_i.ready = s_rdy[0] && !trig_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (s_rdy[0]) begin
        sv_q[0] <= sprite_i.valid && sprite_i.ready;
      end
      for (int i = 1; i < 5; i++) begin
        if (s_rdy[i]) begin
          sv_q[i] <= sv_q[i-1];
        end
      end
      if (emit) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_rdy[0]) begin
      sp_q[0] <= sp_in;
    end
    for (int i = 1; i < 5; i++) begin
      if (s_rdy[i]) begin
        sp_q[i] <= sp_nxt[i-1];
      end
    end
  end

  // Corner pipeline: scale, rotate, sum, round and clamp
  c1_t     c1_q, c1_in;
  c2_t     c2_q, c2_in;
  c3_t     c3_q, c3_in;
  vertex_t c4_q, c4_in;

  always_comb begin
    logic signed [OFF_W-1:0]  offx, offy;
    logic signed [OFF_W+16:0] mx, my;
    spr_t                     s;
    s    = sp_q[4];
    offx = cnt_q[0] ? s.offx1 : s.offx0;
    offy = cnt_q[1] ? s.offy1 : s.offy0;
    mx   = offx * $signed({1'b0, s.sx});
    my   = offy * $signed({1'b0, s.sy});
    c1_in.k     = cnt_q;
    c1_in.ox    = mx[OX_W-1:0];
    c1_in.oy    = my[OX_W-1:0];
    c1_in.basex = s.basex;
    c1_in.basey = s.basey;
    c1_in.u     = s.sat[cnt_q[0]] ? 16'hFFFF : s.quo[cnt_q[0]];
    c1_in.v     = s.sat[2 + cnt_q[1]] ? 16'hFFFF : s.quo[2 + cnt_q[1]];
    c1_in.color = s.color;
  end

  always_comb begin
    c2_in.k     = c1_q.k;
    c2_in.pxc   = c1_q.ox * cosine;
    c2_in.pys   = c1_q.oy * sine;
    c2_in.pxs   = c1_q.ox * sine;
    c2_in.pyc   = c1_q.oy * cosine;
    c2_in.basex = c1_q.basex;
    c2_in.basey = c1_q.basey;
    c2_in.u     = c1_q.u;
    c2_in.v     = c1_q.v;
    c2_in.color = c1_q.color;
  end

  always_comb begin
    c3_in.k     = c2_q.k;
    c3_in.rx    = SUM_W'(c2_q.pxc) - SUM_W'(c2_q.pys) + c2_q.basex;
    c3_in.ry    = SUM_W'(c2_q.pxs) + SUM_W'(c2_q.pyc) + c2_q.basey;
    c3_in.u     = c2_q.u;
    c3_in.v     = c2_q.v;
    c3_in.color = c2_q.color;
  end

  always_comb begin
    logic signed [SUM_W-1:0] sxr, syr;
    sxr = c3_q.rx >>> RS;
    syr = c3_q.ry >>> RS;
    if (sxr > VMAX) begin
      sxr = VMAX;
    end else if (sxr < VMIN) begin
      sxr = VMIN;
    end
    if (syr > VMAX) begin
      syr = VMAX;
    end else if (syr < VMIN) begin
      syr = VMIN;
    end
    c4_in.corner     = c3_q.k;
    c4_in.vert_x     = sxr[VERT_W-1:0];
    c4_in.vert_y     = syr[VERT_W-1:0];
    c4_in.tex_u      = c3_q.u;
    c4_in.tex_v      = c3_q.v;
    c4_in.vert_color = c3_q.color;
    c4_in.last       = (c3_q.k == 2'd3);
  end

  assign c_rdy[3] = !cv_q[3] || vert_o.ready;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_rdy[i] = !cv_q[i] || c_rdy[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else begin
      if (c_rdy[0]) begin
        cv_q[0] <= sv_q[4];
      end
      for (int i = 1; i < 4; i++) begin
        if (c_rdy[i]) begin
          cv_q[i] <= cv_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy[0]) begin
      c1_q <= c1_in;
    end
    if (c_rdy[1]) begin
      c2_q <= c2_in;
    end
    if (c_rdy[2]) begin
      c3_q <= c3_in;
    end
    if (c_rdy[3]) begin
      c4_q <= c4_in;
    end
  end

  assign vert_o.valid = cv_q[3];
  assign vert_o.data  = c4_q;

  // Checks
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_o.valid |-> (vert_o.data.last == (vert_o.data.corner == 2'd3)))
    else $error("last flag does not match the bottom-right corner");

  a_angle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_req.start |=> trig_busy)
    else $error("angle write did not start the sine/cosine sequencer");

  a_corner_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_q[4] && !c_rdy[0]) |=> $stable(cnt_q))
    else $error("corner count moved while the corner pipeline was stalled");
endmodule

FILE: rtl/sqrs_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine sequencer
// Folds the angle into an octant, evaluates the Taylor series in Q30 with a
// shared multiplier stage and reciprocal multiplications for the constant
// divisions, then maps back.
// ----------------------------------------------------------------------------
module sqrs_trig #(
  parameter int unsigned TRIG_FRAC_BITS = sqrs_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sqrs_pkg::trig_req_t              req_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sine_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cosine_o,
  output logic                             busy_o
);
  import sqrs_pkg::*;

  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned TS = 30 - TRIG_FRAC_BITS;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  trig_state_e       state_q, state_d;
  logic [2:0]        oct_q, oct_d;
  logic [29:0]       th_q, th_d;
  logic [29:0]       t2_q, t2_d;
  logic [30:0]       acc_q, acc_d;
  logic [2:0]        step_q, step_d;
  logic [29:0]       num_q, num_d;
  logic [TRIG_FRAC_BITS:0] s0_q, s0_d;
  logic signed [TW-1:0] sine_q, sine_d, cos_q, cos_d;

  function automatic logic [TRIG_FRAC_BITS:0] to_trig(input logic [30:0] x);
    logic [31:0] t;
    t = {1'b0, x} + (32'd1 << (TS - 1));
    return t[TS +: TRIG_FRAC_BITS + 1];
  endfunction

  always_comb begin
    logic [13:0] r;
    logic [46:0] th_prod;
    logic [59:0] sq;
    logic [29:0] mul_a;
    logic [60:0] mp;
    logic [30:0] rm;
    logic [5:0]  rs;
    logic [60:0] dq;
    logic [29:0] quo;
    logic [TRIG_FRAC_BITS:0] c0, s_u, c_u;
    logic signed [TW-1:0] s_s, c_s;
    state_d = state_q;
    oct_d   = oct_q;
    th_d    = th_q;
    t2_d    = t2_q;
    acc_d   = acc_q;
    step_d  = step_q;
    num_d   = num_q;
    s0_d    = s0_q;
    sine_d  = sine_q;
    cos_d   = cos_q;
    r       = {1'b0, req_i.angle[12:0]};
    th_prod = num_q[13:0] * TWO_PI_Q30;
    sq      = th_q * th_q;
    // The sine finish step multiplies th by the finished sine polynomial.
    mul_a   = (state_q == TRIG_SIN) ? th_q : t2_q;
    mp      = mul_a * acc_q;
    // Division by the series constant: multiply by the rounded-up
    // reciprocal and shift; exact for every dividend below 2^30.
    unique case (step_q)
      3'd0: begin rm = 31'd1908874354; rs = 6'd37; end
      3'd1: begin rm = 31'd1636178018; rs = 6'd36; end
      3'd2: begin rm = 31'd1717986919; rs = 6'd35; end
      3'd3: begin rm = 31'd1431655766; rs = 6'd33; end
      3'd4: begin rm = 31'd1227133514; rs = 6'd36; end
      3'd5: begin rm = 31'd1145324613; rs = 6'd35; end
      3'd6: begin rm = 31'd1431655766; rs = 6'd34; end
      3'd7: begin rm = 31'd1073741824; rs = 6'd31; end
    endcase
    dq      = num_q * rm;
    quo     = 30'(dq >> rs);
    c0      = to_trig(acc_q);
    s_u     = (oct_q[0] ^ oct_q[1]) ? c0 : s0_q;
    c_u     = (oct_q[0] ^ oct_q[1]) ? s0_q : c0;
    s_s     = $signed({1'b0, s_u});
    c_s     = $signed({1'b0, c_u});
    if (req_i.start) begin
      oct_d = req_i.angle[15:13];
      if (req_i.angle[13]) begin
        r = 14'h2000 - r;
      end
      num_d   = {16'd0, r};
      state_d = TRIG_TH;
    end else begin
      unique case (state_q)
        TRIG_IDLE: begin
          state_d = TRIG_IDLE;
        end
        TRIG_TH: begin
          th_d    = th_prod[45:16];
          state_d = TRIG_SQ;
        end
        TRIG_SQ: begin
          t2_d    = sq[59:30];
          acc_d   = ONE_Q30;
          step_d  = 3'd0;
          state_d = TRIG_MUL;
        end
        TRIG_MUL: begin
          num_d   = mp[59:30];
          state_d = TRIG_DIV;
        end
        TRIG_DIV: begin
          acc_d = ONE_Q30 - {1'b0, quo};
          if (step_q == 3'd3) begin
            state_d = TRIG_SIN;
          end else if (step_q == 3'd7) begin
            state_d = TRIG_FIN;
          end else begin
            step_d  = step_q + 3'd1;
            state_d = TRIG_MUL;
          end
        end
        TRIG_SIN: begin
          s0_d    = to_trig({1'b0, mp[59:30]} & 31'h3FFF_FFFF);
          acc_d   = ONE_Q30;
          step_d  = 3'd4;
          state_d = TRIG_MUL;
        end
        TRIG_FIN: begin
          sine_d  = oct_q[2] ? -s_s : s_s;
          cos_d   = (oct_q[1] ^ oct_q[2]) ? -c_s : c_s;
          state_d = TRIG_IDLE;
        end
        default: state_d = TRIG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_IDLE;
      sine_q  <= '0;
      cos_q   <= {{(TW - TRIG_FRAC_BITS - 1){1'b0}}, 1'b1, {TRIG_FRAC_BITS{1'b0}}};
    end else begin
      state_q <= state_d;
      sine_q  <= sine_d;
      cos_q   <= cos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oct_q  <= oct_d;
    th_q   <= th_d;
    t2_q   <= t2_d;
    acc_q  <= acc_d;
    step_q <= step_d;
    num_q  <= num_d;
    s0_q   <= s0_d;
  end

  assign sine_o   = sine_q;
  assign cosine_o = cos_q;
  assign busy_o   = (state_q != TRIG_IDLE) || req_i.start;
endmodule

FILE: tb/sqrs_vertex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad vertex checker
// Watches the configuration port and both streams, predicts the four
// corner vertices of every accepted sprite and compares them in order.
// ----------------------------------------------------------------------------
module sqrs_vertex_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          spr_valid_i,
  input  logic                          spr_ready_i,
  input  sqrs_pkg::sprite_t             spr_data_i,
  input  logic                          vtx_valid_i,
  input  logic                          vtx_ready_i,
  input  sqrs_pkg::vertex_t             vtx_data_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [sqrs_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [sqrs_pkg::PDATA_W-1:0]  pwdata_i,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            sprites_o
);
  import sqrs_pkg::*;

  localparam int unsigned FR    = SCALE_FRAC + 16;
  localparam longint      TWO_PI_Q30 = 64'd6746518852;
  localparam longint      Q30_ONE    = 64'd1 << 30;

  int signed   cfg_pivot_x;
  int signed   cfg_pivot_y;
  int unsigned cfg_tex_w;
  int unsigned cfg_tex_h;
  longint      trig_sin;
  longint      trig_cos;
  vertex_t     corner_q[$];
  int          fails;

  function automatic longint trig_round(longint unsigned q30);
    return longint'((q30 + (64'd1 << 13)) >> 14);
  endfunction

  // Octant-folded Taylor evaluation of sine and cosine for a phase angle.
  task automatic set_angle(input logic [15:0] a);
    int unsigned    oct;
    longint unsigned r, th, t2, p, q;
    longint         s0, c0, s, c;
    oct = a[15:13];
    r   = a[12:0];
    if (oct[0]) r = 64'h2000 - r;
    th = (r * TWO_PI_Q30) >> 16;
    t2 = (th * th) >> 30;
    p  = Q30_ONE - t2 / 72;
    p  = Q30_ONE - ((t2 * p) >> 30) / 42;
    p  = Q30_ONE - ((t2 * p) >> 30) / 20;
    p  = Q30_ONE - ((t2 * p) >> 30) / 6;
    s0 = trig_round((th * p) >> 30);
    q  = Q30_ONE - t2 / 56;
    q  = Q30_ONE - ((t2 * q) >> 30) / 30;
    q  = Q30_ONE - ((t2 * q) >> 30) / 12;
    q  = Q30_ONE - ((t2 * q) >> 30) / 2;
    c0 = trig_round(q);
    if (((oct + 1) >> 1) & 1) begin
      s = c0;
      c = s0;
    end else begin
      s = s0;
      c = c0;
    end
    if (oct >= 4) s = -s;
    if (oct >= 2 && oct <= 5) c = -c;
    trig_sin = s;
    trig_cos = c;
  endtask

  function automatic logic [15:0] tex_coord(longint unsigned n, int unsigned size);
    longint unsigned d, v;
    d = (size == 0) ? 1 : size;
    v = ((n << 16) + d) / (2 * d);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [19:0] screen_coord(longint v);
    longint r;
    r = (v + (64'sd1 <<< (FR - 5))) >>> (FR - 4);
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[19:0];
  endfunction

  task automatic predict_corners(input sprite_t s);
    longint      offx[2], offy[2], bx, by, ox, oy, rx, ry;
    logic [15:0] uu[2], vv[2];
    vertex_t     v;
    offx[0] = -longint'(cfg_pivot_x);
    offx[1] = longint'(s.clip_w) - cfg_pivot_x;
    offy[0] = -longint'(cfg_pivot_y);
    offy[1] = longint'(s.clip_h) - cfg_pivot_y;
    uu[0] = tex_coord(s.clip_x, cfg_tex_w);
    uu[1] = tex_coord(longint'(s.clip_x) + s.clip_w, cfg_tex_w);
    vv[0] = tex_coord(s.clip_y, cfg_tex_h);
    vv[1] = tex_coord(longint'(s.clip_y) + s.clip_h, cfg_tex_h);
    bx = (longint'(s.pos_x) + cfg_pivot_x) * (64'sd1 <<< FR) - (64'sd1 <<< (FR - 1));
    by = (longint'(s.pos_y) + cfg_pivot_y) * (64'sd1 <<< FR) - (64'sd1 <<< (FR - 1));
    for (int k = 0; k < 4; k++) begin
      ox = offx[k & 1] * longint'(s.scale_x);
      oy = offy[k >> 1] * longint'(s.scale_y);
      rx = ox * trig_cos - oy * trig_sin + bx;
      ry = ox * trig_sin + oy * trig_cos + by;
      v.corner     = k[1:0];
      v.vert_x     = screen_coord(rx);
      v.vert_y     = screen_coord(ry);
      v.tex_u      = uu[k & 1];
      v.tex_v      = vv[k >> 1];
      v.vert_color = s.color;
      v.last       = (k == 3);
      corner_q.push_back(v);
    end
  endtask

  task automatic compare_vertex(input vertex_t got);
    vertex_t want;
    if (corner_q.size() == 0) begin
      $display("%0t: vertex with none expected: %p", $time, got);
      fails++;
      return;
    end
    want = corner_q.pop_front();
    if (got.corner !== want.corner || got.vert_x !== want.vert_x ||
        got.vert_y !== want.vert_y || got.tex_u !== want.tex_u ||
        got.tex_v !== want.tex_v || got.vert_color !== want.vert_color ||
        got.last !== want.last) begin
      $display("%0t: vertex mismatch expected %p actual %p", $time, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pivot_x = 0;
      cfg_pivot_y = 0;
      cfg_tex_w   = 256;
      cfg_tex_h   = 256;
      trig_sin    = 0;
      trig_cos    = 64'sd1 <<< 16;
      corner_q.delete();
      fails       = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
      sprites_o  <= 0;
    end else begin
      if (vtx_valid_i && vtx_ready_i) compare_vertex(vtx_data_i);
      if (spr_valid_i && spr_ready_i) begin
        predict_corners(spr_data_i);
        sprites_o <= sprites_o + 1;
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_PIVOT_X:    cfg_pivot_x = $signed(pwdata_i[11:0]);
          REG_PIVOT_Y:    cfg_pivot_y = $signed(pwdata_i[11:0]);
          REG_ROT_ANGLE:  set_angle(pwdata_i[15:0]);
          REG_TEX_WIDTH:  cfg_tex_w = pwdata_i[12:0];
          REG_TEX_HEIGHT: cfg_tex_h = pwdata_i[12:0];
          default: ;
        endcase
      end
      fail_cnt_o <= fails;
      pending_o  <= corner_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad rotate/scale testbench
// Drives sprite requests and register settings with random gaps and
// backpressure; a checker module predicts and compares every vertex.
// ----------------------------------------------------------------------------
module tb;
  import sqrs_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  int                 fail_cnt, pending, sprites;
  bit                 rx_hold_req, rx_hold_done, rx_free, tx_free;
  int                 settings_cnt;

  sqrs_stream_if #(.T(sprite_t)) sprite_if ();
  sqrs_stream_if #(.T(vertex_t)) vert_if ();

  sprite_quad_rotate_scale u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sprite_i(sprite_if),
    .vert_o  (vert_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sqrs_vertex_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .spr_valid_i(sprite_if.valid),
    .spr_ready_i(sprite_if.ready),
    .spr_data_i (sprite_if.data),
    .vtx_valid_i(vert_if.valid),
    .vtx_ready_i(vert_if.ready),
    .vtx_data_i (vert_if.data),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .sprites_o  (sprites)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d vertices outstanding", pending);
    $display("FAILURE");
    $finish;
  end

  // Vertex receiver: random stalls, one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    vert_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !rx_hold_done) begin
        vert_if.ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        rx_hold_done = 1'b1;
      end else if (stall > 0) begin
        stall--;
        vert_if.ready <= 1'b0;
      end else if (rx_free || $urandom_range(0, 99) < 70) begin
        vert_if.ready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
        vert_if.ready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sprite(input sprite_t s);
    int gap;
    sprite_if.valid <= 1'b1;
    sprite_if.data  <= s;
    @(posedge clk_i);
    while (!sprite_if.ready) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      sprite_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    sprite_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // Let the pipeline settle past its latency before touching registers.
    repeat (12) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input int px, input int py, input int ang,
                                input int tw, input int th);
    reg_write({REG_PIVOT_X, 2'b00}, px);
    reg_write({REG_PIVOT_Y, 2'b00}, py);
    reg_write({REG_ROT_ANGLE, 2'b00}, ang);
    reg_write({REG_TEX_WIDTH, 2'b00}, tw);
    reg_write({REG_TEX_HEIGHT, 2'b00}, th);
    settings_cnt++;
  endtask

  // Field extremes chosen by the bits of the index, and the scales by its residues mod 3 and mod 5.
  function automatic sprite_t corner_case(input int i);
    sprite_t s;
    s.pos_x   = i[0] ? 12'sd2047 : -12'sd2048;
    s.pos_y   = i[1] ? 12'sd2047 : -12'sd2048;
    s.clip_x  = i[2] ? 12'hFFF : 12'h000;
    s.clip_y  = i[3] ? 12'hFFF : 12'h000;
    s.clip_w  = i[1] ^ i[2] ? 12'hFFF : 12'h000;
    s.clip_h  = i[0] ^ i[3] ? 12'hFFF : 12'h000;
    s.scale_x = (i % 3 == 0) ? 16'h0000 : (i % 3 == 1) ? 16'hFFFF : 16'h1000;
    s.scale_y = (i % 5 < 2) ? 16'hFFFF : 16'h1000;
    s.color   = i[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
    return s;
  endfunction

  function automatic sprite_t random_sprite();
    logic [159:0] raw;
    sprite_t      s;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    s   = raw[$bits(sprite_t)-1:0];
    if ($urandom_range(0, 3) != 0) begin
      s.clip_w  = 12'($urandom_range(0, 255));
      s.clip_h  = 12'($urandom_range(0, 255));
      s.scale_x = 16'($urandom_range(16'h0400, 16'h3000));
      s.scale_y = 16'($urandom_range(16'h0400, 16'h3000));
    end
    return s;
  endfunction

  initial begin
    rst_ni          = 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    sprite_if.valid <= 1'b0;
    sprite_if.data  <= '0;
    rx_hold_req     = 1'b0;
    rx_hold_done    = 1'b0;
    rx_free         = 1'b0;
    tx_free         = 1'b0;
    settings_cnt    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: directed extremes first.
    for (int i = 0; i < 20; i++) send_sprite(corner_case(i));
    for (int i = 0; i < 30; i++) send_sprite(random_sprite());

    for (int ph = 1; ph < 8; ph++) begin
      wait_drained();
      rx_free = (ph == 4);
      tx_free = (ph == 3 || ph == 4);
      case (ph)
        1: apply_settings(-2048, 2047, 16'h2000, 1, 4096);
        2: begin
          // Zero and oversize texture sizes, plus writes to unmapped addresses.
          apply_settings(2047, -2048, 16'h4000, 0, 8191);
          reg_write(5'd20, 32'hFFFF_FFFF);
          reg_write(5'd28, 32'h0000_1234);
        end
        3: apply_settings(0, 0, 16'hFFFF, 4096, 1);
        default: apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom_range(0, 65535), $urandom_range(1, 4096),
                                $urandom_range(1, 4096));
      endcase
      if (ph <= 3)
        for (int i = 0; i < 4; i++) send_sprite(corner_case($urandom_range(0, 15)));
      for (int i = 0; i < 46; i++) begin
        if (ph == 5 && i == 10) rx_hold_req = 1'b1;
        send_sprite(random_sprite());
      end
    end

    wait_drained();
    $display("Checked %0d sprites over %0d register settings, with stalls on both streams",
             sprites, settings_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d vertices missing", fail_cnt, pending);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sprite_quad_rotate_scale.f
rtl/sqrs_pkg.sv
rtl/sqrs_stream_if.sv
rtl/sqrs_trig.sv
rtl/sprite_quad_rotate_scale.sv
tb/sqrs_vertex_checker.sv
tb/tb.sv
